>>> rtl/held_note_store_assert.svh
// Assertion macros for the held note store checker.
`ifndef HELD_NOTE_STORE_ASSERT_SVH
`define HELD_NOTE_STORE_ASSERT_SVH

// same-cycle implication
`define HNS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HNS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hns_pkg.sv
// Shared types and constants of the held note store.
package hns_pkg;

	localparam int NOTE_COUNT = 128;
	localparam int IDX_W      = $clog2(NOTE_COUNT);
	localparam int CNT_W      = 8;
	localparam int HELD_W     = 22;
	localparam int TAG_W      = 16;
	localparam int VEL_W      = 7;
	localparam int ENT_W      = VEL_W + TAG_W;
	localparam int SLOT_W     = 8;
	localparam int ADDR_W     = 4;

	localparam logic [CNT_W-1:0]  NOTE_LIMIT = CNT_W'(NOTE_COUNT);
	localparam logic [CNT_W-1:0]  LAST_POS   = CNT_W'(NOTE_COUNT - 1);
	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NOTE_COUNT - 1);
	localparam logic [14:0]       COUNT_MAX  = 15'h7fff;
	localparam logic [SLOT_W-1:0] FREE_SLOT  = 8'hff;
	localparam logic [CNT_W-1:0]  CNT_SAT    = 8'hff;

	localparam logic [1:0] MODE_ON    = 2'd0;
	localparam logic [1:0] MODE_OFF   = 2'd1;
	localparam logic [1:0] MODE_MARK  = 2'd2;
	localparam logic [1:0] MODE_PHASE = 2'd3;

	localparam logic [1:0] REG_RELEASE_TAG = 2'd0;
	localparam logic [1:0] REG_REPLY_FLAG  = 2'd1;
	localparam logic [1:0] REG_UNSORTED    = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_USCAN,
		ST_URSCAN,
		ST_INS_CMP,
		ST_INS_FIN,
		ST_SREM,
		ST_TOP_RD,
		ST_TOP_DAT,
		ST_DONE
	} hns_state_t;

	typedef struct packed {
		logic [TAG_W-1:0] release_tag;
		logic [7:0]       reply_flag;
		logic             unsorted_queue;
	} hns_cfg_t;

	typedef struct packed {
		logic              drain_event;
		logic              queue_emptied;
		logic [7:0]        distinct_notes;
		logic [HELD_W-1:0] held_total;
		logic [7:0]        queued_total;
		logic [7:0]        top_note;
		logic [7:0]        reply;
	} hns_res_t;

endpackage

>>> rtl/hns_ram.sv
// Generic simple dual-port RAM with registered read.
module hns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/hns_ctrl.sv
// Event sequencer: count-word read-modify-write and queue walks over the slot RAM.
module hns_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 in_mode,
	input  logic [6:0]                 in_note,
	input  logic [6:0]                 in_vel,
	input  logic [3:0]                 in_phase,
	input  hns_pkg::hns_cfg_t          cfg,
	input  logic                       out_free,
	output logic                       done,
	output hns_pkg::hns_res_t          res,
	output logic                       ent_we,
	output logic [hns_pkg::IDX_W-1:0]  ent_waddr,
	output logic [hns_pkg::ENT_W-1:0]  ent_wdata,
	output logic [hns_pkg::IDX_W-1:0]  ent_raddr,
	input  logic [hns_pkg::ENT_W-1:0]  ent_rdata,
	output logic                       slot_we,
	output logic [hns_pkg::IDX_W-1:0]  slot_waddr,
	output logic [hns_pkg::SLOT_W-1:0] slot_wdata,
	output logic [hns_pkg::IDX_W-1:0]  slot_raddr,
	input  logic [hns_pkg::SLOT_W-1:0] slot_rdata
);
	import hns_pkg::*;

	hns_state_t state_q, state_nxt;

	logic [IDX_W-1:0]  clr_q;
	logic [1:0]        mode_q;
	logic [6:0]        note_q;
	logic [6:0]        vel_q;
	logic [3:0]        phase_in_q;
	logic [7:0]        reply_q;
	logic [CNT_W-1:0]  slot_cnt_q;
	logic [HELD_W-1:0] held_q;
	logic [7:0]        distinct_q;
	logic [SLOT_W-1:0] top_q;
	logic [TAG_W-1:0]  last_tag_q;
	logic [3:0]        phase_q;
	logic              marked_q;
	logic              emptied_q;
	logic              drain_q;
	logic [CNT_W-1:0]  pos_q;
	logic [SLOT_W-1:0] carry_q;
	logic [NOTE_COUNT-1:0] queued_q;

	logic [IDX_W-1:0]  note_idx;
	logic [IDX_W-1:0]  pos_idx;
	logic [TAG_W-1:0]  ent_word;
	logic [14:0]       cnt;
	logic [VEL_W-1:0]  ent_vel;
	logic              is_on;
	logic              note_ok;
	logic              cnt_full;
	logic              cnt_zero;
	logic [TAG_W-1:0]  off_word;
	logic              queued_n;
	logic [CNT_W-1:0]  cnt_clamp;
	logic [CNT_W-1:0]  top_pos;
	logic [CNT_W-1:0]  exec_rd;
	logic              ins_stop;
	logic              slot_hit;
	logic              drain_ok;

	assign note_idx  = note_q[IDX_W-1:0];
	assign pos_idx   = pos_q[IDX_W-1:0];
	assign ent_word  = ent_rdata[TAG_W-1:0];
	assign ent_vel   = ent_rdata[ENT_W-1:TAG_W];
	assign cnt       = ent_word[14:0];
	assign is_on     = (mode_q != MODE_OFF) && (vel_q != 7'd0);
	assign note_ok   = {1'b0, note_q} < NOTE_LIMIT;
	assign cnt_full  = cnt == COUNT_MAX;
	assign cnt_zero  = cnt == 15'd0;
	assign off_word  = {1'b0, cnt - 15'd1} | cfg.release_tag;
	assign queued_n  = queued_q[note_idx];
	assign cnt_clamp = (slot_cnt_q > NOTE_LIMIT) ? NOTE_LIMIT : slot_cnt_q;
	assign top_pos   = cnt_clamp - 8'd1;
	assign exec_rd   = (is_on ? slot_cnt_q : cnt_clamp) - 8'd1;
	assign ins_stop  = slot_rdata[7] || (slot_rdata[6:0] < note_q);
	assign slot_hit  = slot_rdata == {1'b0, note_q};
	assign drain_ok  = (cfg.release_tag == '0) && (distinct_q == 8'd0)
		&& (phase_q >= 4'd1) && (phase_q <= 4'd3);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_IDX) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (mode_q == MODE_PHASE || !note_ok) begin
					state_nxt = ST_DONE;
				end else if (is_on) begin
					if (cnt_full || queued_n) state_nxt = ST_DONE;
					else if (cfg.unsorted_queue) state_nxt = ST_USCAN;
					else if (slot_cnt_q >= NOTE_LIMIT) state_nxt = ST_DONE;
					else if (slot_cnt_q == 8'd0) state_nxt = ST_INS_FIN;
					else state_nxt = ST_INS_CMP;
				end else begin
					if (cnt_zero || off_word != '0 || !queued_n) state_nxt = ST_DONE;
					else if (cfg.unsorted_queue) state_nxt = ST_URSCAN;
					else if (cnt_clamp == 8'd0) state_nxt = ST_TOP_RD;
					else state_nxt = ST_SREM;
				end
			end
			ST_USCAN: begin
				if (slot_rdata[7] || pos_q == LAST_POS) state_nxt = ST_DONE;
			end
			ST_URSCAN: begin
				if (slot_hit || pos_q == LAST_POS) state_nxt = ST_TOP_RD;
			end
			ST_INS_CMP: begin
				if (ins_stop) state_nxt = ST_DONE;
				else if (pos_q == 8'd1) state_nxt = ST_INS_FIN;
			end
			ST_INS_FIN: state_nxt = ST_DONE;
			ST_SREM: begin
				if (slot_hit || pos_q == 8'd0) state_nxt = ST_TOP_RD;
			end
			ST_TOP_RD: begin
				state_nxt = (slot_cnt_q != 8'd0) ? ST_TOP_DAT : ST_DONE;
			end
			ST_TOP_DAT: state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ent_we     = 1'b0;
		ent_waddr  = note_idx;
		ent_wdata  = '0;
		ent_raddr  = in_note[IDX_W-1:0];
		slot_we    = 1'b0;
		slot_waddr = pos_idx;
		slot_wdata = {1'b0, note_q};
		slot_raddr = pos_idx;
		in_ready   = state_q == ST_IDLE;
		done       = (state_q == ST_DONE) && out_free;
		unique case (state_q)
			ST_CLEAR: begin
				ent_we     = 1'b1;
				ent_waddr  = clr_q;
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = FREE_SLOT;
			end
			ST_EXEC: begin
				if (mode_q != MODE_PHASE && note_ok) begin
					if (is_on && !cnt_full) begin
						ent_we    = 1'b1;
						ent_wdata = {vel_q, 1'b0, cnt + 15'd1};
					end else if (!is_on && !cnt_zero) begin
						ent_we    = 1'b1;
						ent_wdata = {ent_vel, off_word};
					end
				end
				slot_raddr = cfg.unsorted_queue ? '0 : exec_rd[IDX_W-1:0];
			end
			ST_USCAN: begin
				slot_we    = slot_rdata[7];
				slot_raddr = pos_idx + IDX_W'(1);
			end
			ST_URSCAN: begin
				slot_we    = slot_hit;
				slot_wdata = FREE_SLOT;
				slot_raddr = pos_idx + IDX_W'(1);
			end
			ST_INS_CMP: begin
				slot_we    = 1'b1;
				slot_wdata = ins_stop ? {1'b0, note_q} : slot_rdata;
				slot_raddr = pos_idx - IDX_W'(2);
			end
			ST_INS_FIN: begin
				slot_we = 1'b1;
			end
			ST_SREM: begin
				slot_we    = 1'b1;
				slot_wdata = carry_q;
				slot_raddr = pos_idx - IDX_W'(1);
			end
			ST_TOP_RD: begin
				slot_raddr = top_pos[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			mode_q     <= '0;
			note_q     <= '0;
			vel_q      <= '0;
			phase_in_q <= '0;
			reply_q    <= '0;
			slot_cnt_q <= '0;
			held_q     <= '0;
			distinct_q <= '0;
			top_q      <= FREE_SLOT;
			last_tag_q <= '0;
			phase_q    <= '0;
			marked_q   <= 1'b0;
			emptied_q  <= 1'b0;
			drain_q    <= 1'b0;
			pos_q      <= '0;
			carry_q    <= FREE_SLOT;
			queued_q   <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + IDX_W'(1);
				ST_IDLE: begin
					if (in_valid) begin
						mode_q     <= in_mode;
						note_q     <= in_note;
						vel_q      <= in_vel;
						phase_in_q <= in_phase;
						reply_q    <= '0;
						emptied_q  <= 1'b0;
						drain_q    <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (mode_q == MODE_PHASE) begin
						phase_q <= phase_in_q;
					end else if (note_ok) begin
						if (mode_q == MODE_MARK) marked_q <= 1'b1;
						if (is_on) begin
							if (cnt_full) begin
								reply_q <= 8'd1;
							end else begin
								held_q  <= held_q + HELD_W'(1);
								reply_q <= cfg.reply_flag;
								if (ent_word == '0) distinct_q <= distinct_q + 8'd1;
								pos_q <= cfg.unsorted_queue ? '0 : slot_cnt_q;
							end
						end else if (!cnt_zero) begin
							last_tag_q <= cfg.release_tag;
							held_q     <= held_q - HELD_W'(1);
							reply_q    <= cfg.reply_flag;
							if (off_word == '0) begin
								if (distinct_q != 8'd0) distinct_q <= distinct_q - 8'd1;
								if (queued_n) begin
									queued_q[note_idx] <= 1'b0;
									if (!cfg.unsorted_queue && slot_cnt_q != 8'd0) begin
										slot_cnt_q <= slot_cnt_q - 8'd1;
									end
								end
							end
							pos_q   <= cfg.unsorted_queue ? '0 : exec_rd;
							carry_q <= FREE_SLOT;
						end
					end
				end
				ST_USCAN: begin
					if (slot_rdata[7]) begin
						queued_q[note_idx] <= 1'b1;
						if (slot_cnt_q != CNT_SAT) slot_cnt_q <= slot_cnt_q + 8'd1;
						top_q <= {1'b0, note_q};
					end else begin
						pos_q <= pos_q + 8'd1;
					end
				end
				ST_URSCAN: begin
					if (slot_hit) begin
						if (slot_cnt_q != 8'd0) slot_cnt_q <= slot_cnt_q - 8'd1;
					end else begin
						pos_q <= pos_q + 8'd1;
					end
				end
				ST_INS_CMP: begin
					if (ins_stop) begin
						queued_q[note_idx] <= 1'b1;
						if (slot_cnt_q != CNT_SAT) slot_cnt_q <= slot_cnt_q + 8'd1;
						top_q <= {1'b0, note_q};
					end else begin
						pos_q <= pos_q - 8'd1;
					end
				end
				ST_INS_FIN: begin
					queued_q[note_idx] <= 1'b1;
					if (slot_cnt_q != CNT_SAT) slot_cnt_q <= slot_cnt_q + 8'd1;
					top_q <= {1'b0, note_q};
				end
				ST_SREM: begin
					carry_q <= slot_rdata;
					pos_q   <= pos_q - 8'd1;
				end
				ST_TOP_RD: begin
					if (slot_cnt_q == 8'd0) begin
						top_q     <= FREE_SLOT;
						emptied_q <= 1'b1;
						if (drain_ok) begin
							phase_q <= '0;
							drain_q <= 1'b1;
						end
					end
				end
				ST_TOP_DAT: top_q <= slot_rdata;
				default: begin
				end
			endcase
		end
	end

	assign res.reply          = reply_q;
	assign res.top_note       = top_q;
	assign res.queued_total   = slot_cnt_q;
	assign res.held_total     = held_q;
	assign res.distinct_notes = distinct_q;
	assign res.queue_emptied  = emptied_q;
	assign res.drain_event    = drain_q;

endmodule

>>> rtl/held_note_store.sv
// Top level of the held note store: config port, memories and output register.
//
// Input stream s_axis carries one note event per item (note on, note off,
// marked note on, phase write). Each item returns exactly one result item on
// m_axis with the reply byte and the store's counters after the event.
// The user writes configuration over the APB-style port only while the
// block is idle; the block itself does not enforce this. A queue insert or
// removal steps through the slot RAM one entry per cycle. The next item is
// taken once the result is in the output register, even if the receiver has
// not yet taken it; a stalled receiver holds back only the following item's
// completion. After reset the block sweeps both RAMs, one entry per cycle,
// before it raises s_axis_tready; config writes are taken meanwhile.
module held_note_store (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [23:0]                s_axis_tdata,  // mode, note, velocity, phase_value
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// reply, top_note, queued_total, held_total, distinct_notes, queue_emptied, drain_event
	output logic [55:0]                m_axis_tdata,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hns_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import hns_pkg::*;

	hns_cfg_t cfg_q;
	hns_res_t res;
	hns_res_t m_data_q;
	logic     m_valid_q;
	logic     out_free;
	logic     done;

	logic              ent_we;
	logic [IDX_W-1:0]  ent_waddr;
	logic [ENT_W-1:0]  ent_wdata;
	logic [IDX_W-1:0]  ent_raddr;
	logic [ENT_W-1:0]  ent_rdata;
	logic              slot_we;
	logic [IDX_W-1:0]  slot_waddr;
	logic [SLOT_W-1:0] slot_wdata;
	logic [IDX_W-1:0]  slot_raddr;
	logic [SLOT_W-1:0] slot_rdata;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_RELEASE_TAG: cfg_q.release_tag    <= pwdata[TAG_W-1:0];
				REG_REPLY_FLAG:  cfg_q.reply_flag     <= pwdata[7:0];
				REG_UNSORTED:    cfg_q.unsorted_queue <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RELEASE_TAG: prdata = {16'd0, cfg_q.release_tag};
			REG_REPLY_FLAG:  prdata = {24'd0, cfg_q.reply_flag};
			REG_UNSORTED:    prdata = {31'd0, cfg_q.unsorted_queue};
			default:         prdata = '0;
		endcase
	end

	hns_ram #(.WIDTH(ENT_W), .DEPTH(NOTE_COUNT)) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	hns_ram #(.WIDTH(SLOT_W), .DEPTH(NOTE_COUNT)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	hns_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_mode    (s_axis_tdata[1:0]),
		.in_note    (s_axis_tdata[8:2]),
		.in_vel     (s_axis_tdata[15:9]),
		.in_phase   (s_axis_tdata[19:16]),
		.cfg        (cfg_q),
		.out_free   (out_free),
		.done       (done),
		.res        (res),
		.ent_we     (ent_we),
		.ent_waddr  (ent_waddr),
		.ent_wdata  (ent_wdata),
		.ent_raddr  (ent_raddr),
		.ent_rdata  (ent_rdata),
		.slot_we    (slot_we),
		.slot_waddr (slot_waddr),
		.slot_wdata (slot_wdata),
		.slot_raddr (slot_raddr),
		.slot_rdata (slot_rdata)
	);

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_data_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

>>> rtl/hns_checker.sv
// Port-level assertions for the held note store, bound to the top level.
`include "held_note_store_assert.svh"

module hns_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	`HNS_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
	`HNS_ASSERT_IMP(a_empty_top, clk, arst_n, m_axis_tvalid && m_axis_tdata[54], (m_axis_tdata[23:16] == 8'd0) && (m_axis_tdata[15:8] == 8'hff), "emptied flag with queue not empty")
	`HNS_ASSERT_IMP(a_drain_empty, clk, arst_n, m_axis_tvalid && m_axis_tdata[55], m_axis_tdata[54], "drain event without emptied queue")

endmodule

bind held_note_store hns_checker u_hns_checker (.*);

>>> verif/held_note_store_test.sv
// Testbench of the held note store: directed and random note events checked against a predictor.
`timescale 1ns / 1ps

module held_note_store_test;
	import hns_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [1:0] mode;
		logic [6:0] note;
		logic [6:0] vel;
		logic [3:0] phase;
		bit         typed;
		hns_res_t   res;
	} event_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state
	logic [15:0] count_word [NOTE_COUNT];
	logic [6:0]  velocity_mem [NOTE_COUNT];
	logic [7:0]  slot_mem [NOTE_COUNT];
	bit          in_queue [NOTE_COUNT];
	int unsigned slot_cnt, held_cnt, distinct_cnt, top_slot, phase_reg;
	bit          marked;
	logic [15:0] tag_reg;
	logic [7:0]  reply_reg;
	bit          unsorted_reg;
	bit          emptied_now, drain_now;

	hns_res_t    pending_results [$];
	bit          idle_en = 1'b1;
	bit          failed = 1'b0;
	int unsigned cycles = 0;
	int          ready_hold = 0;

	held_note_store u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			ready_hold <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		hns_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = hns_res_t'(m_axis_tdata);
			if (pending_results.size() == 0) begin
				$error("result item with no expectation: %h", m_axis_tdata);
				failed = 1'b1;
			end else begin
				want = pending_results.pop_front();
				if (got.reply !== want.reply) begin
					$error("reply exp %0d got %0d", want.reply, got.reply); failed = 1'b1;
				end
				if (got.top_note !== want.top_note) begin
					$error("top_note exp %0d got %0d", want.top_note, got.top_note);
					failed = 1'b1;
				end
				if (got.queued_total !== want.queued_total) begin
					$error("queued_total exp %0d got %0d", want.queued_total,
						got.queued_total);
					failed = 1'b1;
				end
				if (got.held_total !== want.held_total) begin
					$error("held_total exp %0d got %0d", want.held_total, got.held_total);
					failed = 1'b1;
				end
				if (got.distinct_notes !== want.distinct_notes) begin
					$error("distinct_notes exp %0d got %0d", want.distinct_notes,
						got.distinct_notes);
					failed = 1'b1;
				end
				if (got.queue_emptied !== want.queue_emptied) begin
					$error("queue_emptied exp %0d got %0d", want.queue_emptied,
						got.queue_emptied);
					failed = 1'b1;
				end
				if (got.drain_event !== want.drain_event) begin
					$error("drain_event exp %0d got %0d", want.drain_event,
						got.drain_event);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic int unsigned clamp_slots();
		return slot_cnt > NOTE_COUNT ? NOTE_COUNT : slot_cnt;
	endfunction

	function automatic void dequeue_note(int unsigned nt);
		int unsigned n, idx;
		logic [7:0] carry, v;
		if (!in_queue[nt])
			return;
		if (unsorted_reg) begin
			for (int i = 0; i < NOTE_COUNT; i++) begin
				if (slot_mem[i] == 8'(nt)) begin
					slot_mem[i] = FREE_SLOT;
					if (slot_cnt > 0)
						slot_cnt--;
					break;
				end
			end
		end else begin
			n = clamp_slots();
			if (slot_cnt > 0)
				slot_cnt--;
			carry = FREE_SLOT;
			idx = n;
			while (idx > 0) begin
				idx--;
				v = slot_mem[idx];
				slot_mem[idx] = carry;
				carry = v;
				if (v == 8'(nt))
					break;
			end
		end
		in_queue[nt] = 1'b0;
		if (slot_cnt > 0) begin
			top_slot = 32'(slot_mem[clamp_slots() - 1]);
			return;
		end
		top_slot = 32'(FREE_SLOT);
		emptied_now = 1'b1;
		if (tag_reg != 0 || distinct_cnt != 0)
			return;
		if (phase_reg >= 1 && phase_reg <= 3) begin
			phase_reg = 0;
			drain_now = 1'b1;
		end
	endfunction

	function automatic logic [7:0] release_note(int unsigned nt);
		int unsigned c;
		c = 32'(count_word[nt][14:0]);
		if (c == 0)
			return 8'd0;
		count_word[nt] = 16'(c - 1) | tag_reg;
		held_cnt = (held_cnt - 1) & 32'h3fffff;
		if (count_word[nt] == 0) begin
			if (distinct_cnt != 0)
				distinct_cnt--;
			dequeue_note(nt);
		end
		return reply_reg;
	endfunction

	function automatic logic [7:0] press_note(int unsigned nt, logic [6:0] vel);
		logic [15:0] w;
		int pos;
		logic [7:0] v;
		if (vel == 0)
			return release_note(nt);
		w = count_word[nt];
		if (w[14:0] == COUNT_MAX)
			return 8'd1;
		count_word[nt] = {1'b0, w[14:0] + 15'd1};
		held_cnt = (held_cnt + 1) & 32'h3fffff;
		if (w == 0)
			distinct_cnt = (distinct_cnt + 1) & 8'hff;
		velocity_mem[nt] = vel;
		if (in_queue[nt])
			return reply_reg;
		if (unsorted_reg) begin
			for (pos = 0; pos < NOTE_COUNT; pos++)
				if (slot_mem[pos][7])
					break;
			if (pos >= NOTE_COUNT)
				return reply_reg;
		end else begin
			if (slot_cnt >= NOTE_COUNT)
				return reply_reg;
			pos = slot_cnt;
			while (pos > 0) begin
				v = slot_mem[pos - 1];
				if ($signed(v) < $signed({1'b0, 7'(nt)}))
					break;
				slot_mem[pos] = v;
				pos--;
			end
		end
		slot_mem[pos] = 8'(nt);
		in_queue[nt] = 1'b1;
		if (slot_cnt < 255)
			slot_cnt++;
		top_slot = nt;
		return reply_reg;
	endfunction

	function automatic hns_res_t predict_event(logic [1:0] mode, logic [6:0] nt,
			logic [6:0] vel, logic [3:0] ph);
		hns_res_t r;
		r.reply = 8'd0;
		emptied_now = 1'b0;
		drain_now = 1'b0;
		if (mode == MODE_PHASE)
			phase_reg = 32'(ph);
		else if (mode == MODE_OFF)
			r.reply = release_note(32'(nt));
		else begin
			if (mode == MODE_MARK)
				marked = 1'b1;
			r.reply = press_note(32'(nt), vel);
		end
		r.top_note = 8'(top_slot);
		r.queued_total = 8'(slot_cnt);
		r.held_total = 22'(held_cnt);
		r.distinct_notes = 8'(distinct_cnt);
		r.queue_emptied = emptied_now;
		r.drain_event = drain_now;
		return r;
	endfunction

	task automatic send_event(logic [1:0] mode, logic [6:0] nt, logic [6:0] vel,
			logic [3:0] ph, bit typed = 1'b0, hns_res_t typed_res = '0);
		hns_res_t r;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, ph, vel, nt, mode};
		do @(posedge clk); while (!s_axis_tready);
		r = predict_event(mode, nt, vel, ph);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		s_axis_tvalid <= 1'b0;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(idx) << 2;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_RELEASE_TAG: tag_reg = val[15:0];
			REG_REPLY_FLAG:  reply_reg = val[7:0];
			REG_UNSORTED:    unsorted_reg = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_config(logic [15:0] tag, logic [7:0] rf, bit uns);
		write_reg(REG_RELEASE_TAG, 32'(tag));
		write_reg(REG_REPLY_FLAG, 32'(rf));
		write_reg(REG_UNSORTED, 32'(uns));
	endtask

	event_row_t rows [] = '{
		'{MODE_OFF,   7'd0,   7'd0,   4'd0, 1, '{0, 0, 8'd0, 22'd0, 8'd0, 8'hff, 8'd0}},
		'{MODE_PHASE, 7'd0,   7'd0,   4'd2, 1, '{0, 0, 8'd0, 22'd0, 8'd0, 8'hff, 8'd0}},
		'{MODE_ON,    7'd127, 7'd127, 4'd0, 1, '{0, 0, 8'd1, 22'd1, 8'd1, 8'd127, 8'd0}},
		'{MODE_ON,    7'd0,   7'd1,   4'd0, 1, '{0, 0, 8'd2, 22'd2, 8'd2, 8'd0, 8'd0}},
		'{MODE_OFF,   7'd0,   7'd0,   4'd15, 1, '{0, 0, 8'd1, 22'd1, 8'd1, 8'd127, 8'd0}},
		'{MODE_MARK,  7'd127, 7'd0,   4'd0, 1, '{1, 1, 8'd0, 22'd0, 8'd0, 8'hff, 8'd0}},
		// sticky tag, reply flag, marked note-on
		'{MODE_ON,    7'd64,  7'd85,  4'd0, 0, '0},
		'{MODE_OFF,   7'd64,  7'd0,   4'd0, 0, '0},
		'{MODE_ON,    7'd64,  7'd42,  4'd0, 0, '0},
		'{MODE_MARK,  7'd3,   7'd127, 4'd0, 0, '0},
		'{MODE_ON,    7'd3,   7'd0,   4'd0, 0, '0},
		'{MODE_OFF,   7'd64,  7'd0,   4'd0, 0, '0},
		'{MODE_PHASE, 7'd0,   7'd0,   4'd3, 0, '0},
		'{MODE_OFF,   7'd3,   7'd0,   4'd0, 0, '0},
		'{MODE_OFF,   7'd64,  7'd0,   4'd0, 0, '0},
		// unsorted queue
		'{MODE_ON,    7'd90,  7'd1,   4'd0, 0, '0},
		'{MODE_ON,    7'd10,  7'd2,   4'd0, 0, '0},
		'{MODE_ON,    7'd50,  7'd3,   4'd0, 0, '0},
		'{MODE_OFF,   7'd10,  7'd0,   4'd0, 0, '0},
		'{MODE_ON,    7'd20,  7'd4,   4'd0, 0, '0},
		'{MODE_PHASE, 7'd0,   7'd0,   4'd1, 0, '0},
		'{MODE_OFF,   7'd90,  7'd0,   4'd0, 0, '0},
		'{MODE_OFF,   7'd50,  7'd0,   4'd0, 0, '0},
		'{MODE_OFF,   7'd20,  7'd0,   4'd0, 0, '0}
	};

	initial begin
		int base, span;
		logic [1:0] md;
		for (int i = 0; i < NOTE_COUNT; i++) begin
			count_word[i] = '0;
			velocity_mem[i] = '0;
			slot_mem[i] = FREE_SLOT;
			in_queue[i] = 1'b0;
		end
		slot_cnt = 0; held_cnt = 0; distinct_cnt = 0; top_slot = 32'(FREE_SLOT);
		phase_reg = 0; marked = 1'b0;
		tag_reg = '0; reply_reg = '0; unsorted_reg = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < rows.size(); i++) begin
			if (i == 6) begin
				drain_results();
				set_config(16'h8000, 8'ha5, 1'b0);
			end else if (i == 15) begin
				drain_results();
				set_config(16'h0000, 8'h5a, 1'b1);
			end
			send_event(rows[i].mode, rows[i].note, rows[i].vel, rows[i].phase,
				rows[i].typed, rows[i].res);
		end

		for (int p = 0; p < 7; p++) begin
			drain_results();
			case (p)
				0: set_config(16'hffff, 8'hff, 1'b1);
				1: set_config(16'h0000, 8'h00, 1'b0);
				default: set_config($urandom_range(0, 1) ? 16'h0000 : 16'($urandom),
					8'($urandom), 1'($urandom_range(0, 1)));
			endcase
			if (p == 6)
				idle_en = 1'b0;
			// mostly on/off traffic over a random window of notes
			span = (p == 2) ? 128 : $urandom_range(2, 24);
			base = $urandom_range(0, 128 - span);
			for (int k = 0; k < 85; k++) begin
				case ($urandom_range(0, 9))
					0: md = MODE_PHASE;
					1: md = MODE_MARK;
					2, 3, 4, 5: md = MODE_ON;
					default: md = MODE_OFF;
				endcase
				send_event(md, 7'($urandom_range(base, base + span - 1)),
					$urandom_range(0, 5) == 0 ? 7'd0 : 7'($urandom),
					4'($urandom_range(0, 15)));
			end
		end

		// a few closing events on one note
		drain_results();
		set_config(16'h0000, 8'h33, 1'b0);
		send_event(MODE_ON, 7'd9, 7'd127, 4'd0);
		send_event(MODE_MARK, 7'd9, 7'd1, 4'd0);
		send_event(MODE_OFF, 7'd9, 7'd0, 4'd0);

		drain_results();
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
